/* rtl/expl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expl_pkg
// Shared types and constants of the expression lexer: token codes, run
// states, character constants and the result record.
// ----------------------------------------------------------------------------
package expl_pkg;

  // token class codes
  localparam logic [3:0] TK_INT    = 4'd0;
  localparam logic [3:0] TK_IDENT  = 4'd1;
  localparam logic [3:0] TK_LPAREN = 4'd2;
  localparam logic [3:0] TK_RPAREN = 4'd3;
  localparam logic [3:0] TK_PLUS   = 4'd4;
  localparam logic [3:0] TK_MINUS  = 4'd5;
  localparam logic [3:0] TK_TIMES  = 4'd6;
  localparam logic [3:0] TK_DIVIDE = 4'd7;
  localparam logic [3:0] TK_OTHER  = 4'd8;
  localparam logic [3:0] TK_END    = 4'd9;

  // character constants
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    RUN_NONE  = 2'd0,
    RUN_INT   = 2'd1,
    RUN_IDENT = 2'd2
  } run_state_t;

  typedef struct packed {
    logic [3:0]  token_class;
    logic [31:0] token_value;
    logic [7:0]  token_length;
    logic [7:0]  single_char;
    logic        overflowed;
    logic        last_of_run;
  } token_t;

  // results produced by one item, written to the queue together in the same cycle
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage
`default_nettype wire

/* rtl/expl_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expl_in_if / expl_out_if
// Valid/ready channels of the expression lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface expl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;

  modport source (output valid, output source_byte, output end_of_input, input ready);
  modport sink   (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface expl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_class;
  logic [31:0] token_value;
  logic [7:0]  token_length;
  logic [7:0]  single_char;
  logic        overflowed;
  logic        last_of_run;

  modport source (output valid, output token_class, output token_value,
                  output token_length, output single_char, output overflowed,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_class, input token_value,
                  input token_length, input single_char, input overflowed,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/expl_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expl_core
// Input register and lexing logic: classifies the registered byte, updates
// the pending run and produces up to two tokens for the result queue.
// ----------------------------------------------------------------------------
module expl_core import expl_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] source_byte,
  input  wire logic       end_of_input,
  output push_t           push
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_LEN);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eoi_r;

  run_state_t  pend_r, pend_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        ovf_r, ovf_nxt;

  logic        is_digit, is_letter, is_space, has_run;
  logic [3:0]  digit;
  logic [35:0] prod;
  logic [31:0] sat_val;
  logic        dig_ovf;
  logic [7:0]  len_step;
  logic        len_ovf;
  token_t      run_tok, end_tok, one_tok;
  logic [3:0]  one_cls;

  always_comb begin
    is_digit  = (s1_byte_r >= CH_ZERO) && (s1_byte_r <= CH_NINE);
    is_letter = ((s1_byte_r >= 8'h61) && (s1_byte_r <= 8'h7A)) ||
                ((s1_byte_r >= 8'h41) && (s1_byte_r <= 8'h5A)) ||
                (s1_byte_r == CH_UNDERSCORE);
    is_space  = (s1_byte_r == CH_SPACE) ||
                ((s1_byte_r >= CH_TAB) && (s1_byte_r <= CH_CR));
    has_run   = (pend_r == RUN_INT) || (pend_r == RUN_IDENT);
    digit     = 4'(s1_byte_r - CH_ZERO);

    // value * 10 + digit as two shifted adds
    prod    = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, digit};
    dig_ovf = (prod[35:32] != 4'd0);
    sat_val = dig_ovf ? 32'hFFFF_FFFF : prod[31:0];

    // length saturates at the maximum, later characters only flag it
    len_ovf  = (len_r >= MAX_LEN);
    len_step = len_ovf ? len_r : len_r + 8'd1;

    case (s1_byte_r)
      CH_LPAREN: one_cls = TK_LPAREN;
      CH_RPAREN: one_cls = TK_RPAREN;
      CH_PLUS:   one_cls = TK_PLUS;
      CH_MINUS:  one_cls = TK_MINUS;
      CH_STAR:   one_cls = TK_TIMES;
      CH_SLASH:  one_cls = TK_DIVIDE;
      default:   one_cls = TK_OTHER;
    endcase

    run_tok.token_class  = (pend_r == RUN_INT) ? TK_INT : TK_IDENT;
    run_tok.token_value  = (pend_r == RUN_INT) ? acc_r : 32'd0;
    run_tok.token_length = len_r;
    run_tok.single_char  = 8'd0;
    run_tok.overflowed   = ovf_r;
    run_tok.last_of_run  = 1'b0;

    end_tok = '0;
    end_tok.token_class = TK_END;
    end_tok.last_of_run = 1'b1;

    one_tok.token_class  = one_cls;
    one_tok.token_value  = 32'd0;
    one_tok.token_length = 8'd1;
    one_tok.single_char  = s1_byte_r;
    one_tok.overflowed   = 1'b0;
    one_tok.last_of_run  = 1'b1;

    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    push     = '0;

    if (s1_valid_r) begin
      if (s1_eoi_r || is_space || !(is_digit || is_letter)) begin
        // flush any pending run, then append the end or one-character token (none for a space)
        pend_nxt = RUN_NONE;
        acc_nxt  = 32'd0;
        len_nxt  = 8'd0;
        ovf_nxt  = 1'b0;
        if (has_run) begin
          push.tok0 = run_tok;
          push.cnt  = 2'd1;
          if (s1_eoi_r) begin
            push.tok1 = end_tok;
            push.cnt  = 2'd2;
          end else if (!is_space) begin
            push.tok1 = one_tok;
            push.cnt  = 2'd2;
          end else begin
            push.tok0.last_of_run = 1'b1;
          end
        end else if (s1_eoi_r) begin
          push.tok0 = end_tok;
          push.cnt  = 2'd1;
        end else if (!is_space) begin
          push.tok0 = one_tok;
          push.cnt  = 2'd1;
        end
      end else if ((is_digit && pend_r == RUN_INT) ||
                   (is_letter && pend_r == RUN_IDENT)) begin
        len_nxt = len_step;
        ovf_nxt = ovf_r | len_ovf | (is_digit & dig_ovf);
        acc_nxt = is_digit ? sat_val : acc_r;
      end else begin
        // start a new run, closing any pending run of the other class
        if (has_run) begin
          push.tok0 = run_tok;
          push.tok0.last_of_run = 1'b1;
          push.cnt  = 2'd1;
        end
        pend_nxt = is_digit ? RUN_INT : RUN_IDENT;
        len_nxt  = 8'd1;
        ovf_nxt  = 1'b0;
        acc_nxt  = is_digit ? {28'd0, digit} : 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pend_r     <= RUN_NONE;
      acc_r      <= 32'd0;
      len_r      <= 8'd0;
      ovf_r      <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      pend_r     <= pend_nxt;
      acc_r      <= acc_nxt;
      len_r      <= len_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= source_byte;
      s1_eoi_r  <= end_of_input;
    end
  end

endmodule
`default_nettype wire

/* rtl/expl_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expl_queue
// Small result queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module expl_queue import expl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire push_t       push,
  input  wire logic        pop,
  output token_t           head,
  output logic             not_empty,
  output logic [QCNT_W-1:0] count
);

  token_t              q_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [QPTR_W-1:0]   wr_ptr1;

  assign wr_ptr1   = wr_ptr_r + QPTR_W'(1);
  assign head      = q_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;
  assign cnt_nxt   = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push.cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push.tok0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_ptr1] <= push.tok1;
    end
  end

endmodule
`default_nettype wire

/* rtl/expression_lexer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expression_lexer_top
// Byte-serial tokenizer for arithmetic expressions.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while in_ch.ready is high. Each byte is
// registered, lexed in the next cycle against the pending run, and its tokens
// (none, one or two) are written into a four-entry result queue; the first
// token of a byte passes the input register and then the queue register
// before it shows on out_ch. in_ch.ready is high while the queue holds at most
// two tokens including those the registered byte is writing, so with a ready
// sink the block runs at one byte per cycle; a byte that yields two tokens
// keeps the output busy for both, and the queue drain of one token per cycle
// then sets the input rate.
// ----------------------------------------------------------------------------
module expression_lexer_top import expl_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 128
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  expl_in_if.sink    in_ch,
  expl_out_if.source out_ch
);

  push_t             push;
  token_t            head;
  logic              not_empty;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   fill;
  logic              accept;
  logic              pop;

  assign fill         = {1'b0, q_count} + (QCNT_W + 1)'(push.cnt);
  assign in_ch.ready  = (fill <= (QCNT_W + 1)'(QDEPTH - 2));
  assign accept       = in_ch.valid && in_ch.ready;
  assign pop          = not_empty && out_ch.ready;

  expl_core #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .source_byte  (in_ch.source_byte),
    .end_of_input (in_ch.end_of_input),
    .push         (push)
  );

  expl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (q_count)
  );

  assign out_ch.valid        = not_empty;
  assign out_ch.token_class  = head.token_class;
  assign out_ch.token_value  = head.token_value;
  assign out_ch.token_length = head.token_length;
  assign out_ch.single_char  = head.single_char;
  assign out_ch.overflowed   = head.overflowed;
  assign out_ch.last_of_run  = head.last_of_run;

endmodule
`default_nettype wire

/* rtl/expl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// expl_checker
// Port-level checks on the token stream of the expression lexer.
// ----------------------------------------------------------------------------
module expl_checker import expl_pkg::*; #(
  parameter int MAX_TOKEN_LEN = 128
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  token_class,
  input wire logic [31:0] token_value,
  input wire logic [7:0]  token_length,
  input wire logic [7:0]  single_char,
  input wire logic        overflowed,
  input wire logic        last_of_run
);

  // a stalled item holds its class, value, length and last_of_run flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_class) &&
      $stable(token_value) && $stable(token_length) && $stable(last_of_run))
    else $error("stalled token changed");

  // the end token closes its item and carries nothing
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_class == TK_END |-> last_of_run && token_length == 8'd0 &&
      token_value == 32'd0 && !overflowed)
    else $error("bad end token");

  // a one-character token is always the final token of its item
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_class >= TK_LPAREN && token_class <= TK_OTHER |->
      last_of_run && token_length == 8'd1 && token_value == 32'd0 && !overflowed)
    else $error("bad one-character token");

  // run tokens stay within the saturated length
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (token_class == TK_INT || token_class == TK_IDENT) |->
      token_length >= 8'd1 && token_length <= 8'(MAX_TOKEN_LEN) && single_char == 8'd0)
    else $error("bad run token");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> token_class <= TK_END)
    else $error("token class out of range");

endmodule

bind expression_lexer_top expl_checker #(
  .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
) u_expl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_class  (out_ch.token_class),
  .token_value  (out_ch.token_value),
  .token_length (out_ch.token_length),
  .single_char  (out_ch.single_char),
  .overflowed   (out_ch.overflowed),
  .last_of_run  (out_ch.last_of_run)
);
`default_nettype wire
